@@ rtl/lru_pkg.sv @@
// Shared constants, types and control structs for the LRU tag store.
// No dependencies; every other file in rtl/ depends on this package.
package lru_pkg;

	localparam int NUM_ENTRIES = 16;
	localparam int KEY_BITS    = 64;
	localparam int STAMP_BITS  = 32;
	localparam int SLOT_BITS   = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
	localparam int CNT_BITS    = $clog2(NUM_ENTRIES + 1);

	// fixed widths of the channel fields
	localparam int KEY_W  = 64;
	localparam int SIZE_W = 20;
	localparam int SLOT_W = 4;

	typedef enum logic {
		CMD_QUERY = 1'b0,
		CMD_ADD   = 1'b1
	} lru_cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_COMMIT,
		ST_OUTPUT
	} lru_state_t;

	typedef struct packed {
		logic                 rd_en;
		logic [SLOT_BITS-1:0] rd_addr;
	} lru_rd_t;

	typedef struct packed {
		logic                  wr_entry;
		logic                  wr_stamp;
		logic [SLOT_BITS-1:0]  addr;
		logic [KEY_BITS-1:0]   key;
		logic [SIZE_W-1:0]     size;
		logic [STAMP_BITS-1:0] stamp;
	} lru_wr_t;

	typedef struct packed {
		logic                 clear;
		logic                 eval;
		logic [SLOT_BITS-1:0] idx;
	} lru_eval_t;

	typedef struct packed {
		logic                 found;
		logic [SLOT_BITS-1:0] match_idx;
		logic [SIZE_W-1:0]    match_size;
		logic [SLOT_BITS-1:0] best_idx;
	} lru_scan_res_t;

	typedef struct packed {
		logic              hit;
		logic [SLOT_W-1:0] slot;
		logic [SIZE_W-1:0] size_out;
		logic              evicted;
	} lru_result_t;

endpackage

@@ rtl/lru_if.sv @@
// Request and response channel interfaces (valid/ready) for the LRU tag store.
// Depends on lru_pkg for field widths.
interface lru_req_if;
	logic                      valid;
	logic                      ready;
	logic                      cmd;
	logic [lru_pkg::KEY_W-1:0]  key;
	logic [lru_pkg::SIZE_W-1:0] object_size;

	modport source (output valid, output cmd, output key, output object_size, input ready);
	modport sink   (input valid, input cmd, input key, input object_size, output ready);
endinterface

interface lru_rsp_if;
	logic                      valid;
	logic                      ready;
	logic                      hit;
	logic [lru_pkg::SLOT_W-1:0] slot;
	logic [lru_pkg::SIZE_W-1:0] size_out;
	logic                      evicted;

	modport source (output valid, output hit, output slot, output size_out, output evicted,
		input ready);
	modport sink   (input valid, input hit, input slot, input size_out, input evicted,
		output ready);
endinterface

@@ rtl/lru_store.sv @@
// Entry memory: key, size and stamp arrays, one write port, one registered read port.
// Depends on lru_pkg.
module lru_store (
	input  logic                              clk,
	input  lru_pkg::lru_rd_t                  rd,
	input  lru_pkg::lru_wr_t                  wr,
	output logic [lru_pkg::KEY_BITS-1:0]      rd_key_q,
	output logic [lru_pkg::SIZE_W-1:0]        rd_size_q,
	output logic [lru_pkg::STAMP_BITS-1:0]    rd_stamp_q
);
	import lru_pkg::*;

	logic [KEY_BITS-1:0]   key_mem   [NUM_ENTRIES];
	logic [SIZE_W-1:0]     size_mem  [NUM_ENTRIES];
	logic [STAMP_BITS-1:0] stamp_mem [NUM_ENTRIES];

	always_ff @(posedge clk) begin
		if (wr.wr_entry) begin
			key_mem[wr.addr]  <= wr.key;
			size_mem[wr.addr] <= wr.size;
		end
		if (wr.wr_entry || wr.wr_stamp) begin
			stamp_mem[wr.addr] <= wr.stamp;
		end
	end

	always_ff @(posedge clk) begin
		if (rd.rd_en) begin
			rd_key_q   <= key_mem[rd.rd_addr];
			rd_size_q  <= size_mem[rd.rd_addr];
			rd_stamp_q <= stamp_mem[rd.rd_addr];
		end
	end

endmodule

@@ rtl/lru_scan.sv @@
// Shared compare unit: one entry per cycle, tracks first key match and oldest stamp.
// Depends on lru_pkg.
module lru_scan (
	input  logic                           clk,
	input  logic                           arst_n,
	input  lru_pkg::lru_eval_t             ev,
	input  logic [lru_pkg::KEY_BITS-1:0]   rd_key,
	input  logic [lru_pkg::SIZE_W-1:0]     rd_size,
	input  logic [lru_pkg::STAMP_BITS-1:0] rd_stamp,
	input  logic [lru_pkg::KEY_BITS-1:0]   lkup_key,
	input  logic [lru_pkg::CNT_BITS-1:0]   fill,
	input  logic [lru_pkg::STAMP_BITS-1:0] stamp_now,
	output lru_pkg::lru_scan_res_t         res
);
	import lru_pkg::*;

	logic                  found_q;
	logic [SLOT_BITS-1:0]  match_idx_q;
	logic [SIZE_W-1:0]     match_size_q;
	logic [SLOT_BITS-1:0]  best_idx_q;
	logic [STAMP_BITS-1:0] best_age_q;

	logic [STAMP_BITS-1:0] age;
	logic                  in_use;
	logic                  key_hit;
	logic                  take_match;
	logic                  take_best;

	// age wraps with the stamp counter
	assign age        = stamp_now - rd_stamp;
	assign in_use     = CNT_BITS'(ev.idx) < fill;
	assign key_hit    = in_use && (rd_key == lkup_key);
	assign take_match = ev.eval && !found_q && key_hit;
	// strict compare keeps the lowest slot on ties
	assign take_best  = ev.eval && ((ev.idx == '0) || (age > best_age_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ev.clear) begin
			found_q <= 1'b0;
		end else if (take_match) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_match) begin
			match_idx_q  <= ev.idx;
			match_size_q <= rd_size;
		end
		if (take_best) begin
			best_idx_q <= ev.idx;
			best_age_q <= age;
		end
	end

	assign res.found      = found_q;
	assign res.match_idx  = match_idx_q;
	assign res.match_size = match_size_q;
	assign res.best_idx   = best_idx_q;

endmodule

@@ rtl/lru_ctrl.sv @@
// Sequencer: accepts a request, steps the scan, commits the entry update, builds the result.
// Holds fill count and stamp counter. Depends on lru_pkg.
module lru_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           cmd,
	input  logic [lru_pkg::KEY_W-1:0]      key,
	input  logic [lru_pkg::SIZE_W-1:0]     object_size,
	input  logic                           out_free,
	output logic                           out_load,
	output lru_pkg::lru_result_t           result,
	output lru_pkg::lru_rd_t               rd,
	output lru_pkg::lru_wr_t               wr,
	output lru_pkg::lru_eval_t             ev,
	input  lru_pkg::lru_scan_res_t         res,
	output logic [lru_pkg::CNT_BITS-1:0]   fill,
	output logic [lru_pkg::STAMP_BITS-1:0] stamp_now,
	output logic [lru_pkg::KEY_BITS-1:0]   lkup_key
);
	import lru_pkg::*;

	lru_state_t            state_q, state_d;
	lru_cmd_t              cmd_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [SIZE_W-1:0]     size_q;
	logic [CNT_BITS-1:0]   fill_q;
	logic [STAMP_BITS-1:0] stamp_q;
	logic [SLOT_BITS-1:0]  idx_q;
	logic                  rd_vld_s1;
	logic [SLOT_BITS-1:0]  rd_idx_s1;
	logic                  direct_q;
	lru_result_t           result_q;

	logic                  accept;
	logic                  has_free;
	logic [SLOT_BITS-1:0]  target;
	logic                  is_add;

	assign has_free = fill_q < CNT_BITS'(NUM_ENTRIES);
	assign accept   = (state_q == ST_IDLE) && in_valid;
	assign is_add   = (cmd_q == CMD_ADD);

	always_comb begin
		priority if (direct_q) begin
			target = fill_q[SLOT_BITS-1:0];
		end else if (is_add) begin
			target = res.best_idx;
		end else begin
			target = res.match_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		out_load    = 1'b0;
		rd.rd_en    = 1'b0;
		rd.rd_addr  = idx_q;
		ev.clear    = 1'b0;
		ev.eval     = rd_vld_s1;
		ev.idx      = rd_idx_s1;
		wr.wr_entry = 1'b0;
		wr.wr_stamp = 1'b0;
		wr.addr     = target;
		wr.key      = key_q;
		wr.size     = size_q;
		wr.stamp    = stamp_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ev.clear = 1'b1;
					if ((cmd == CMD_ADD) && has_free) begin
						state_d = ST_COMMIT;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				rd.rd_en = 1'b1;
				if (idx_q == SLOT_BITS'(NUM_ENTRIES - 1)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				// last read lands in the compare unit this cycle
				state_d = ST_COMMIT;
			end
			ST_COMMIT: begin
				wr.wr_entry = is_add;
				wr.wr_stamp = !is_add && res.found;
				state_d     = ST_OUTPUT;
			end
			ST_OUTPUT: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			stamp_q   <= '0;
			rd_vld_s1 <= 1'b0;
			direct_q  <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == ST_SCAN);
			if (accept) begin
				direct_q <= (cmd == CMD_ADD) && has_free;
			end
			if (wr.wr_entry || wr.wr_stamp) begin
				stamp_q <= stamp_q + 1'b1;
			end
			if ((state_q == ST_COMMIT) && direct_q) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= idx_q;
		if (accept) begin
			cmd_q  <= lru_cmd_t'(cmd);
			key_q  <= key[KEY_BITS-1:0];
			size_q <= object_size;
			idx_q  <= '0;
		end else if (state_q == ST_SCAN) begin
			idx_q <= idx_q + 1'b1;
		end
		if (state_q == ST_COMMIT) begin
			result_q.hit      <= !is_add && res.found;
			result_q.evicted  <= is_add && !direct_q;
			result_q.size_out <= (!is_add && res.found) ? res.match_size : '0;
			if (is_add || res.found) begin
				result_q.slot <= SLOT_W'(target);
			end else begin
				result_q.slot <= '0;
			end
		end
	end

	assign result    = result_q;
	assign fill      = fill_q;
	assign stamp_now = stamp_q;
	assign lkup_key  = key_q;

endmodule

@@ rtl/lru_tag_store.sv @@
// Fully associative LRU tag store of NUM_ENTRIES entries. One request at a time: a query,
// or an add once every slot is full, passes through accept, a scan of every entry (one
// entry read per cycle from the single read port of the entry memory), drain, commit and
// output; an add into a free slot skips the scan and drain.
// The result sits in an output register, so the next request is taken while it waits.
// No clearing pass after reset: slots become valid in fill order, tracked by a fill count.
// Depends on lru_pkg, lru_if, lru_store, lru_scan and lru_ctrl.
module lru_tag_store (
	input  logic       clk,
	input  logic       arst_n,
	lru_req_if.sink    req,
	lru_rsp_if.source  rsp
);
	import lru_pkg::*;

	lru_rd_t               rd;
	lru_wr_t               wr;
	lru_eval_t             ev;
	lru_scan_res_t         res;
	lru_result_t           result;
	logic                  out_load;
	logic                  out_free;
	logic [CNT_BITS-1:0]   fill;
	logic [STAMP_BITS-1:0] stamp_now;
	logic [KEY_BITS-1:0]   lkup_key;
	logic [KEY_BITS-1:0]   rd_key;
	logic [SIZE_W-1:0]     rd_size;
	logic [STAMP_BITS-1:0] rd_stamp;

	logic                  out_valid_q;
	lru_result_t           out_q;

	lru_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (req.valid),
		.in_ready    (req.ready),
		.cmd         (req.cmd),
		.key         (req.key),
		.object_size (req.object_size),
		.out_free    (out_free),
		.out_load    (out_load),
		.result      (result),
		.rd          (rd),
		.wr          (wr),
		.ev          (ev),
		.res         (res),
		.fill        (fill),
		.stamp_now   (stamp_now),
		.lkup_key    (lkup_key)
	);

	lru_store u_store (
		.clk        (clk),
		.rd         (rd),
		.wr         (wr),
		.rd_key_q   (rd_key),
		.rd_size_q  (rd_size),
		.rd_stamp_q (rd_stamp)
	);

	lru_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.ev        (ev),
		.rd_key    (rd_key),
		.rd_size   (rd_size),
		.rd_stamp  (rd_stamp),
		.lkup_key  (lkup_key),
		.fill      (fill),
		.stamp_now (stamp_now),
		.res       (res)
	);

	assign out_free = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= result;
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.hit      = out_q.hit;
	assign rsp.slot     = out_q.slot;
	assign rsp.size_out = out_q.size_out;
	assign rsp.evicted  = out_q.evicted;

`ifndef SYNTHESIS
	// replacement only happens on a full table
	a_evict_full: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.evicted) |-> (fill == CNT_BITS'(NUM_ENTRIES)))
		else $error("eviction reported while free slots remain");

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.hit) |-> !rsp.evicted)
		else $error("result flags both hit and eviction");

	a_idle_no_scan: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> (!rd.rd_en && !wr.wr_entry && !wr.wr_stamp))
		else $error("entry memory active while accepting a request");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> out_free)
		else $error("result loaded over an untaken result");
`endif

endmodule

@@ sim/lru_tag_store_checker.sv @@
`timescale 1ns / 1ps
// Result checker for lru_tag_store: watches the request and response channels,
// predicts each result from its own copy of the table and compares field by field.
// Depends on lru_pkg and the channel interfaces in lru_if.
module lru_tag_store_checker (
	input  logic clk,
	input  logic arst_n,
	lru_req_if   req,
	lru_rsp_if   rsp,
	output int   mismatches,
	output int   outstanding,
	output int   hits,
	output int   evictions
);
	import lru_pkg::*;

	logic [KEY_BITS-1:0]    tag_key   [NUM_ENTRIES];
	logic [SIZE_W-1:0]      tag_size  [NUM_ENTRIES];
	logic [STAMP_BITS-1:0]  tag_stamp [NUM_ENTRIES];
	logic [NUM_ENTRIES-1:0] tag_valid;
	int                     fill_cnt;
	logic [STAMP_BITS-1:0]  use_clock;
	lru_result_t            pending_results[$];
	lru_result_t            want, got;

	// Apply one request to the shadow table and return the result it should produce.
	function automatic lru_result_t lookup_or_fill(lru_cmd_t op, logic [KEY_W-1:0] key_in,
		logic [SIZE_W-1:0] size_in);
		lru_result_t           res;
		int                    target;
		logic [STAMP_BITS-1:0] age;
		logic [STAMP_BITS-1:0] oldest;
		res = '0;
		if (op == CMD_QUERY) begin
			// lowest matching slot wins; a miss leaves the use clock alone
			for (int i = 0; i < NUM_ENTRIES; i++) begin
				if (!res.hit && tag_valid[i] && tag_key[i] == key_in[KEY_BITS-1:0]) begin
					res.hit      = 1'b1;
					res.slot     = SLOT_W'(i);
					res.size_out = tag_size[i];
					tag_stamp[i] = use_clock;
					use_clock    = use_clock + 1'b1;
				end
			end
		end else begin
			if (fill_cnt < NUM_ENTRIES) begin
				target   = fill_cnt;
				fill_cnt = fill_cnt + 1;
			end else begin
				// oldest by modular age, so the choice survives counter wrap
				target = 0;
				oldest = '0;
				for (int i = 0; i < NUM_ENTRIES; i++) begin
					age = use_clock - tag_stamp[i];
					if (i == 0 || age > oldest) begin
						oldest = age;
						target = i;
					end
				end
				res.evicted = 1'b1;
			end
			tag_key[target]   = key_in[KEY_BITS-1:0];
			tag_size[target]  = size_in;
			tag_valid[target] = 1'b1;
			tag_stamp[target] = use_clock;
			use_clock         = use_clock + 1'b1;
			res.slot          = SLOT_W'(target);
		end
		return res;
	endfunction

	task automatic check_field(string field, logic [31:0] want_v, logic [31:0] got_v);
		if (want_v !== got_v) begin
			mismatches++;
			$display("%0t: %s expected %0d actual %0d", $time, field, want_v, got_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_valid = '0;
			fill_cnt  = 0;
			use_clock = '0;
			pending_results.delete();
			outstanding = 0;
		end else begin
			// a result never leaves in the cycle its request arrives, so retire first
			if (rsp.valid && rsp.ready) begin
				got.hit      = rsp.hit;
				got.slot     = rsp.slot;
				got.size_out = rsp.size_out;
				got.evicted  = rsp.evicted;
				if (pending_results.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result transfer, expected none, %s",
						$time, "actual:");
					$display("  hit=%0b slot=%0d size=%0d evicted=%0b",
						got.hit, got.slot, got.size_out, got.evicted);
				end else begin
					want = pending_results.pop_front();
					check_field("hit", 32'(want.hit), 32'(got.hit));
					check_field("slot", 32'(want.slot), 32'(got.slot));
					check_field("size_out", 32'(want.size_out), 32'(got.size_out));
					check_field("evicted", 32'(want.evicted), 32'(got.evicted));
					if (want.hit)
						hits++;
					if (want.evicted)
						evictions++;
				end
			end
			if (req.valid && req.ready)
				pending_results.push_back(lookup_or_fill(lru_cmd_t'(req.cmd), req.key,
					req.object_size));
			outstanding = pending_results.size();
		end
	end

endmodule

@@ sim/lru_tag_store_tb.sv @@
`timescale 1ns / 1ps
// Top of the lru_tag_store testbench: clock, reset, request and response traffic.
// Depends on lru_pkg, lru_if, the RTL and lru_tag_store_checker.
module lru_tag_store_tb;
	import lru_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_ITEMS = 575;
	localparam int KEY_POOL     = 24;
	localparam int HOLD_CYCLES  = 200;
	localparam int DRAIN_CYCLES = 2 * (NUM_ENTRIES + 4);

	logic clk;
	logic arst_n;
	int   mismatches, outstanding, hits, evictions;
	int   cycle_cnt;
	int   sent_cnt;
	int   send_max_gap;
	bit   hold_rsp;
	logic [KEY_W-1:0] key_pool [KEY_POOL];

	lru_req_if req();
	lru_rsp_if rsp();

	lru_tag_store DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	lru_tag_store_checker result_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.rsp         (rsp),
		.mismatches  (mismatches),
		.outstanding (outstanding),
		.hits        (hits),
		.evictions   (evictions)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("Timeout after %0d cycles", cycle_cnt);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic send_req(lru_cmd_t op, logic [KEY_W-1:0] key_in, logic [SIZE_W-1:0] size_in);
		int gap;
		gap = $urandom_range(0, send_max_gap);
		if (gap > 0) begin
			req.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req.cmd         = op;
		req.key         = key_in;
		req.object_size = size_in;
		req.valid       = 1'b1;
		do @(posedge clk); while (!req.ready);
		@(negedge clk);
		sent_cnt++;
	endtask

	// response side: random stalls, occasional no-stall stretches, one long hold-off
	initial begin
		int gap;
		int rsp_max_gap;
		rsp.ready   = 1'b0;
		rsp_max_gap = 11;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 31) == 0)
				rsp_max_gap = ($urandom_range(0, 2) == 0) ? 0 : 11;
			gap = $urandom_range(0, rsp_max_gap);
			if (hold_rsp) begin
				gap      = HOLD_CYCLES;
				hold_rsp = 1'b0;
			end
			if (gap > 0) begin
				rsp.ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			rsp.ready = 1'b1;
			do @(posedge clk); while (!rsp.valid);
			@(negedge clk);
		end
	end

	initial begin
		logic [KEY_W-1:0]  k;
		logic [SIZE_W-1:0] sz;
		lru_cmd_t          op;
		arst_n          = 1'b0;
		req.valid       = 1'b0;
		req.cmd         = CMD_QUERY;
		req.key         = '0;
		req.object_size = '0;
		hold_rsp        = 1'b0;
		send_max_gap    = 11;
		sent_cnt        = 0;
		for (int i = 0; i < KEY_POOL; i++)
			key_pool[i] = {$urandom, $urandom};
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: empty table, key and size extremes, duplicates, fill and eviction
		send_req(CMD_QUERY, '0, '0);
		send_req(CMD_ADD, '0, '0);
		send_req(CMD_ADD, '1, '1);
		send_req(CMD_QUERY, '1, '0);
		send_req(CMD_QUERY, '0, '1);
		send_req(CMD_ADD, '1, 20'h5a5a5);
		send_req(CMD_QUERY, '1, '0);
		send_req(CMD_QUERY, 64'h1, '0);
		for (int i = 3; i < NUM_ENTRIES; i++)
			send_req(CMD_ADD, key_pool[i], SIZE_W'(i * 4099));
		send_req(CMD_ADD, 64'h8000_0000_0000_0000, 20'h80000);
		send_req(CMD_ADD, key_pool[0], '1);
		send_req(CMD_QUERY, '0, '0);
		send_req(CMD_QUERY, '1, '0);

		// random: keys mostly from a pool a bit larger than the table, so queries
		// hit and miss and adds keep evicting
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 40 == 0)
				send_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 11;
			if (n == RANDOM_ITEMS / 2)
				hold_rsp = 1'b1;
			op = ($urandom_range(0, 99) < 35) ? CMD_ADD : CMD_QUERY;
			if ($urandom_range(0, 99) < 8)
				k = {$urandom, $urandom};
			else
				k = key_pool[$urandom_range(0, KEY_POOL - 1)];
			sz = SIZE_W'($urandom);
			send_req(op, k, sz);
		end
		req.valid = 1'b0;

		while (outstanding != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Checked %0d requests: %0d query hits, %0d LRU evictions,", sent_cnt, hits,
			evictions);
		$display("random stalls on both sides and one long response hold-off.");
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
